// ----- src/fsc_pkg.sv -----
// Shared types and constants of the threaded-code stack machine core.
package fsc_pkg;

	typedef enum logic [3:0] {
		ACT_CALL    = 4'd0,
		ACT_DUP     = 4'd1,
		ACT_SWAP    = 4'd2,
		ACT_DROP    = 4'd3,
		ACT_NOT     = 4'd4,
		ACT_ADD     = 4'd5,
		ACT_EXIT    = 4'd6,
		ACT_LITERAL = 4'd7,
		ACT_IF      = 4'd8,
		ACT_ELSE    = 4'd9,
		ACT_BEGIN   = 4'd10,
		ACT_BYE     = 4'd11,
		ACT_NOP     = 4'd12,
		ACT_RESTART = 4'd13
	} act_t;

	typedef enum logic [2:0] {
		FLT_NONE    = 3'd0,
		FLT_DUNDER  = 3'd1,
		FLT_DOVER   = 3'd2,
		FLT_RUNDER  = 3'd3,
		FLT_ROVER   = 3'd4
	} flt_t;

	typedef enum logic [2:0] {
		STK_HOLD = 3'd0,
		STK_PUSH = 3'd1,
		STK_POP  = 3'd2,
		STK_SWAP = 3'd3,
		STK_LOAD = 3'd4
	} stk_op_t;

	localparam logic REG_START_ADDR = 1'b0;

	localparam logic [31:0] TRUE_CELL = 32'h01;

	typedef struct packed {
		logic [15:0]        next_ip;
		logic signed [31:0] top_value;
		logic [6:0]         data_depth;
		logic [6:0]         return_depth;
		logic               halted;
		logic [2:0]         fault;
	} rslt_t;

endpackage

// ----- src/fsc_stack.sv -----
// Stack with a registered top entry, a memory below it and a prefetched second entry.
module fsc_stack #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         en,
	input  fsc_pkg::stk_op_t             op,
	input  logic [WIDTH-1:0]             top_d,
	input  logic [$clog2(DEPTH+1)-1:0]   load_cnt,
	output logic [WIDTH-1:0]             top,
	output logic [WIDTH-1:0]             second,
	output logic [$clog2(DEPTH+1)-1:0]   cnt,
	output logic [$clog2(DEPTH+1)-1:0]   cnt_d
);

	localparam int CW = $clog2(DEPTH + 1);
	localparam int IW = $clog2(DEPTH);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] top_q;
	logic [WIDTH-1:0] second_q;
	logic [CW-1:0]    cnt_q;
	logic [CW-1:0]    wptr;
	logic [CW-1:0]    rptr;
	logic [IW-1:0]    waddr;
	logic [IW-1:0]    raddr;
	logic             we;

	always_comb begin
		cnt_d = cnt_q;
		if (en) begin
			case (op)
				fsc_pkg::STK_PUSH: cnt_d = cnt_q + CW'(1);
				fsc_pkg::STK_POP:  cnt_d = cnt_q - CW'(1);
				fsc_pkg::STK_LOAD: cnt_d = load_cnt;
				default:           cnt_d = cnt_q;
			endcase
		end
	end

	assign we    = en && (op == fsc_pkg::STK_PUSH || op == fsc_pkg::STK_SWAP);
	assign wptr  = (op == fsc_pkg::STK_PUSH) ? cnt_q - CW'(1) : cnt_q - CW'(2);
	assign rptr  = cnt_d - CW'(2);
	assign waddr = wptr[IW-1:0];
	assign raddr = rptr[IW-1:0];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= top_q;
		end
		if (we && waddr == raddr) begin
			second_q <= top_q;
		end else begin
			second_q <= mem[raddr];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			top_q <= top_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else begin
			cnt_q <= cnt_d;
		end
	end

	assign top    = top_q;
	assign second = second_q;
	assign cnt    = cnt_q;

endmodule

// ----- src/fsc_outq.sv -----
// Two-entry result queue: output register plus skid stage.
module fsc_outq (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  fsc_pkg::rslt_t din,
	output logic           full,
	output logic           out_valid,
	input  logic           out_ready,
	output fsc_pkg::rslt_t dout
);

	fsc_pkg::rslt_t out_q;
	fsc_pkg::rslt_t skid_q;
	logic           out_valid_q;
	logic           skid_valid_q;
	logic           drain;

	assign drain = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else begin
			if (drain) begin
				out_valid_q  <= skid_valid_q || push;
				skid_valid_q <= 1'b0;
			end else if (push) begin
				skid_valid_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (drain) begin
			if (skid_valid_q) begin
				out_q <= skid_q;
			end else if (push) begin
				out_q <= din;
			end
		end else if (push) begin
			skid_q <= din;
		end
	end

	assign full      = skid_valid_q;
	assign out_valid = out_valid_q;
	assign dout      = out_q;

endmodule

// ----- src/forth_stack_core.sv -----
// Top level of the threaded-code stack machine core.
//
// Each transfer on the input channel (in_valid/in_ready) carries one decoded
// cell: action, operand and target_addr. The cell executes in the cycle of its
// transfer against the instruction pointer, both stacks and the halt state, and
// its result (next_ip, top_value, depths, halted, fault) is registered and shown
// on the output channel (out_valid/out_ready) from the next cycle on unless the
// output register is stalled, in which case it waits in the skid stage.
// Throughput: one cell per cycle while in_ready is high; the loop through the
// stack top registers and the instruction pointer closes combinationally.
// A two-entry result queue separates the channels: when the receiver stalls,
// one more cell is still taken, and in_ready falls only while both entries
// are full.
// Reset leaves the core halted with empty stacks and the instruction pointer
// at zero; only a restart cell starts execution from start_addr, which is
// written over the APB port (offset 0x0).
module forth_stack_core #(
	parameter int STACK_DEPTH = 64,
	parameter int ADDR_WIDTH  = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [2:0]         paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [3:0]         action,
	input  logic signed [31:0] operand,
	input  logic [15:0]        target_addr,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [15:0]        next_ip,
	output logic signed [31:0] top_value,
	output logic [6:0]         data_depth,
	output logic [6:0]         return_depth,
	output logic               halted,
	output logic [2:0]         fault
);

	localparam int CNT_W = $clog2(STACK_DEPTH + 1);
	localparam int AW    = ADDR_WIDTH;

	logic [15:0]           start_q;
	logic [AW-1:0]         ip_q;
	logic                  halt_q;
	fsc_pkg::flt_t         fault_q;

	logic [AW-1:0]         ip_d;
	logic                  halt_d;
	fsc_pkg::flt_t         fault_d;
	fsc_pkg::flt_t         flt;
	fsc_pkg::act_t         act;
	logic                  commit;
	logic                  q_full;

	logic [AW-1:0]         ip1;
	logic [AW-1:0]         ip2;
	logic [AW-1:0]         ip_rel;
	logic [AW-1:0]         tgt;
	logic [AW-1:0]         start_ip;

	fsc_pkg::stk_op_t      d_op;
	logic [31:0]           d_top;
	logic [31:0]           d_tos;
	logic [31:0]           d_nos;
	logic [CNT_W-1:0]      d_cnt;
	logic [CNT_W-1:0]      d_cnt_d;

	fsc_pkg::stk_op_t      r_op;
	logic [AW-1:0]         r_top;
	logic [AW-1:0]         r_tos;
	logic [AW-1:0]         r_nos;
	logic [CNT_W-1:0]      r_cnt;
	logic [CNT_W-1:0]      r_cnt_d;

	logic                  d_empty;
	logic                  d_short;
	logic                  d_full;
	logic                  r_empty;
	logic                  r_full;

	fsc_pkg::rslt_t        res;
	fsc_pkg::rslt_t        res_q;

	// configuration port
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_q <= '0;
		end else if (psel && penable && pwrite) begin
			unique case (paddr[2])
				fsc_pkg::REG_START_ADDR: start_q <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[2])
			fsc_pkg::REG_START_ADDR: prdata = {16'd0, start_q};
			default:                 prdata = '0;
		endcase
	end

	// execute
	assign in_ready = !q_full;
	assign commit   = in_valid && in_ready;
	assign act      = fsc_pkg::act_t'(action);

	assign ip1      = ip_q + AW'(1);
	assign ip2      = ip_q + AW'(2);
	assign ip_rel   = ip1 + AW'(operand);
	assign tgt      = AW'(32'(target_addr));
	assign start_ip = AW'(32'(start_q));

	assign d_empty = (d_cnt == '0);
	assign d_short = (d_cnt < CNT_W'(2));
	assign d_full  = (d_cnt >= CNT_W'(STACK_DEPTH));
	assign r_empty = (r_cnt == '0);
	assign r_full  = (r_cnt >= CNT_W'(STACK_DEPTH));

	always_comb begin
		ip_d    = ip_q;
		halt_d  = halt_q;
		fault_d = fault_q;
		flt     = fsc_pkg::FLT_NONE;
		d_op    = fsc_pkg::STK_HOLD;
		d_top   = d_tos;
		r_op    = fsc_pkg::STK_HOLD;
		r_top   = r_tos;
		if (act == fsc_pkg::ACT_RESTART) begin
			ip_d    = start_ip;
			halt_d  = 1'b0;
			fault_d = fsc_pkg::FLT_NONE;
			d_op    = fsc_pkg::STK_LOAD;
			r_op    = fsc_pkg::STK_LOAD;
			r_top   = '0;
		end else if (!halt_q) begin
			unique case (act)
				fsc_pkg::ACT_CALL: begin
					if (r_full) flt = fsc_pkg::FLT_ROVER;
					r_op  = fsc_pkg::STK_PUSH;
					r_top = ip1;
					ip_d  = tgt;
				end
				fsc_pkg::ACT_DUP: begin
					if (d_empty) flt = fsc_pkg::FLT_DUNDER;
					else if (d_full) flt = fsc_pkg::FLT_DOVER;
					d_op = fsc_pkg::STK_PUSH;
					ip_d = ip1;
				end
				fsc_pkg::ACT_SWAP: begin
					if (d_short) flt = fsc_pkg::FLT_DUNDER;
					d_op  = fsc_pkg::STK_SWAP;
					d_top = d_nos;
					ip_d  = ip1;
				end
				fsc_pkg::ACT_DROP: begin
					if (d_empty) flt = fsc_pkg::FLT_DUNDER;
					d_op  = fsc_pkg::STK_POP;
					d_top = d_nos;
					ip_d  = ip1;
				end
				fsc_pkg::ACT_NOT: begin
					if (d_empty) flt = fsc_pkg::FLT_DUNDER;
					d_top = (d_tos == '0) ? fsc_pkg::TRUE_CELL : '0;
					ip_d  = ip1;
				end
				fsc_pkg::ACT_ADD: begin
					if (d_short) flt = fsc_pkg::FLT_DUNDER;
					d_op  = fsc_pkg::STK_POP;
					d_top = d_tos + d_nos;
					ip_d  = ip1;
				end
				fsc_pkg::ACT_EXIT: begin
					if (r_empty) flt = fsc_pkg::FLT_RUNDER;
					r_op  = fsc_pkg::STK_POP;
					r_top = r_nos;
					ip_d  = r_tos;
					if (r_tos == '0) halt_d = 1'b1;
				end
				fsc_pkg::ACT_LITERAL: begin
					if (d_full) flt = fsc_pkg::FLT_DOVER;
					d_op  = fsc_pkg::STK_PUSH;
					d_top = operand;
					ip_d  = ip2;
				end
				fsc_pkg::ACT_IF: begin
					if (d_empty) flt = fsc_pkg::FLT_DUNDER;
					d_op  = fsc_pkg::STK_POP;
					d_top = d_nos;
					ip_d  = (d_tos != '0) ? ip2 : ip_rel;
				end
				fsc_pkg::ACT_ELSE: begin
					ip_d = ip_rel;
				end
				fsc_pkg::ACT_BEGIN: begin
					if (r_full) flt = fsc_pkg::FLT_ROVER;
					r_op  = fsc_pkg::STK_PUSH;
					r_top = ip1;
					ip_d  = ip1;
				end
				fsc_pkg::ACT_BYE: begin
					ip_d   = ip1;
					halt_d = 1'b1;
				end
				default: begin
					ip_d = ip1;
				end
			endcase
			if (flt != fsc_pkg::FLT_NONE) begin
				ip_d    = ip_q;
				halt_d  = 1'b1;
				fault_d = flt;
				d_op    = fsc_pkg::STK_HOLD;
				d_top   = d_tos;
				r_op    = fsc_pkg::STK_HOLD;
				r_top   = r_tos;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ip_q    <= '0;
			halt_q  <= 1'b1;
			fault_q <= fsc_pkg::FLT_NONE;
		end else if (commit) begin
			ip_q    <= ip_d;
			halt_q  <= halt_d;
			fault_q <= fault_d;
		end
	end

	fsc_stack #(
		.WIDTH (32),
		.DEPTH (STACK_DEPTH)
	) u_dstack (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (commit),
		.op       (d_op),
		.top_d    (d_top),
		.load_cnt ('0),
		.top      (d_tos),
		.second   (d_nos),
		.cnt      (d_cnt),
		.cnt_d    (d_cnt_d)
	);

	fsc_stack #(
		.WIDTH (AW),
		.DEPTH (STACK_DEPTH)
	) u_rstack (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (commit),
		.op       (r_op),
		.top_d    (r_top),
		.load_cnt (CNT_W'(1)),
		.top      (r_tos),
		.second   (r_nos),
		.cnt      (r_cnt),
		.cnt_d    (r_cnt_d)
	);

	// result
	always_comb begin
		res.next_ip      = 16'(32'(ip_d));
		res.top_value    = (d_cnt_d == '0) ? '0 : d_top;
		res.data_depth   = 7'(d_cnt_d);
		res.return_depth = 7'(r_cnt_d);
		res.halted       = halt_d;
		res.fault        = fault_d;
	end

	fsc_outq u_outq (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (commit),
		.din       (res),
		.full      (q_full),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.dout      (res_q)
	);

	assign next_ip      = res_q.next_ip;
	assign top_value    = res_q.top_value;
	assign data_depth   = res_q.data_depth;
	assign return_depth = res_q.return_depth;
	assign halted       = res_q.halted;
	assign fault        = res_q.fault;

endmodule

// ----- src/fsc_checker.sv -----
// Port-level checks of the stack machine core, bound to the top level.
module fsc_checker #(
	parameter int STACK_DEPTH = 64
) (
	input logic               clk,
	input logic               arst_n,
	input logic               out_valid,
	input logic               out_ready,
	input logic [15:0]        next_ip,
	input logic signed [31:0] top_value,
	input logic [6:0]         data_depth,
	input logic [6:0]         return_depth,
	input logic               halted,
	input logic [2:0]         fault
);

	localparam bit WIDE = (STACK_DEPTH > 127);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(next_ip) && $stable(top_value))
		else $error("result changed while stalled");

	a_fault_halts: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && fault != fsc_pkg::FLT_NONE |-> halted)
		else $error("fault reported without halt");

	a_empty_top: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && data_depth == 7'd0 |-> top_value == 32'sd0)
		else $error("non-zero top on empty data stack");

	a_depth_bound: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !WIDE |->
			data_depth <= 7'(STACK_DEPTH) && return_depth <= 7'(STACK_DEPTH))
		else $error("stack depth beyond capacity");

endmodule

bind forth_stack_core fsc_checker #(
	.STACK_DEPTH (STACK_DEPTH)
) u_fsc_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.out_valid    (out_valid),
	.out_ready    (out_ready),
	.next_ip      (next_ip),
	.top_value    (top_value),
	.data_depth   (data_depth),
	.return_depth (return_depth),
	.halted       (halted),
	.fault        (fault)
);
